// ===== src/assert_macros.svh =====
// Assertion helpers; every use assumes clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("check failed");
`define CHK_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`else
`define CHK_ALWAYS(lbl, expr)
`define CHK_IMPLIES(lbl, ante, cons)
`endif
`endif

// ===== src/rfft_pkg.sv =====
`timescale 1ns / 1ps
package rfft_pkg;

  localparam int ADDR_W    = 10;
  localparam int PTS       = 1024;
  localparam int PTS_LOG2  = 10;
  localparam int TW_DEPTH  = PTS / 2;
  localparam int TW_W      = 9;
  localparam int SMP_W     = 16;
  localparam int DATA_W    = 27;
  localparam int LG_W      = 4;
  localparam logic [LG_W-1:0] SIZE_RESET = 4'd4;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_READ = 1'b1
  } req_t;

  typedef struct packed {
    req_t                     kind;
    logic [ADDR_W-1:0]        addr;
    logic signed [SMP_W-1:0]  re;
    logic signed [SMP_W-1:0]  im;
    logic                     last;
    logic [LG_W-1:0]          lg;
    logic                     done;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic             done;
    logic [LG_W-1:0]  lg;
  } front_stat_t;

  typedef logic signed [SMP_W-1:0] tw_tab_t [TW_DEPTH];

  function automatic longint q30_to_q15(input longint v);
    longint r;
    longint t;
    t = (v < 0) ? 64'sd0 : v;
    r = (t + 64'sd16384) >>> 15;
    return (r > 64'sd32767) ? 64'sd32767 : r;
  endfunction

  // Restoring long division, used only while building the twiddle tables.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q30 Taylor series, thirteen terms; gives the exact twiddle contents.
  function automatic tw_tab_t build_tab(input bit want_sin);
    tw_tab_t tab;
    longint unsigned x, x2, tc, ts, jj;
    longint sc, ss, cq;
    bit flip;
    for (int j = 0; j < TW_DEPTH; j++) begin
      flip = (4 * j > PTS);
      jj   = flip ? longint'(TW_DEPTH - j) : longint'(j);
      x    = (2 * PI_Q30 * jj) >> PTS_LOG2;
      x2   = (x * x) >> 30;
      tc   = ONE_Q30;
      ts   = x;
      sc   = longint'(ONE_Q30);
      ss   = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        tc = udiv((tc * x2) >> 30, longint'((2 * n - 1) * (2 * n)));
        ts = udiv((ts * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
        if ((n & 1) == 1) begin
          sc = sc - longint'(tc);
          ss = ss - longint'(ts);
        end else begin
          sc = sc + longint'(tc);
          ss = ss + longint'(ts);
        end
      end
      cq = q30_to_q15(sc);
      if (want_sin) tab[j] = SMP_W'(q30_to_q15(ss));
      else          tab[j] = SMP_W'(flip ? -cq : cq);
    end
    return tab;
  endfunction

  localparam tw_tab_t COS_TAB = build_tab(1'b0);
  localparam tw_tab_t SIN_TAB = build_tab(1'b1);

endpackage

// ===== src/rfft_ram.sv =====
`timescale 1ns / 1ps
module rfft_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== src/rfft_front.sv =====
`timescale 1ns / 1ps
module rfft_front
  import rfft_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [LG_W-1:0]         cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_req_type,
  input  logic signed [SMP_W-1:0] in_sample_re,
  input  logic signed [SMP_W-1:0] in_sample_im,
  input  logic [ADDR_W-1:0]       in_bin_index,
  input  q_stat_t                 q_st,
  output logic                    push,
  output cmd_t                    push_cmd,
  output front_stat_t             st
);
  logic [LG_W-1:0]   size_r;
  logic [ADDR_W-1:0] cnt_r;
  logic              done_r;
  logic [LG_W-1:0]   lg;
  logic [ADDR_W:0]   n_pts;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] cnt_eff;
  logic              last;

  function automatic logic [ADDR_W-1:0] rev_bits(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    for (int b = 0; b < ADDR_W; b++) r[b] = v[ADDR_W-1-b];
    return r;
  endfunction

  always_comb begin
    priority if (size_r == '0)                         lg = LG_W'(1);
    else if (size_r > LG_W'(PTS_LOG2))                 lg = LG_W'(PTS_LOG2);
    else                                               lg = size_r;
  end

  assign n_pts    = (ADDR_W+1)'(1) << lg;
  assign mask     = ADDR_W'(n_pts - 1'b1);
  assign cnt_eff  = done_r ? '0 : cnt_r;
  assign last     = (cnt_eff == mask);
  assign in_ready = !q_st.full;
  assign push     = in_valid && in_ready;

  // Loads land at the bit-reversed slot, so no reorder pass is needed.
  always_comb begin
    push_cmd.kind = req_t'(in_req_type);
    push_cmd.re   = in_sample_re;
    push_cmd.im   = in_sample_im;
    push_cmd.lg   = lg;
    push_cmd.last = last && (in_req_type == REQ_LOAD);
    push_cmd.done = done_r;
    if (in_req_type == REQ_LOAD)
      push_cmd.addr = rev_bits(cnt_eff) >> (LG_W'(PTS_LOG2) - lg);
    else
      push_cmd.addr = in_bin_index & mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (push && in_req_type == REQ_LOAD) begin
      if (last) begin
        cnt_r  <= '0;
        done_r <= 1'b1;
      end else begin
        cnt_r  <= cnt_eff + 1'b1;
        done_r <= 1'b0;
      end
    end
  end

  assign st.done = done_r;
  assign st.lg   = lg;
endmodule

// ===== src/rfft_queue.sv =====
`timescale 1ns / 1ps
module rfft_queue
  import rfft_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    pop_cmd,
  output q_stat_t st
);
  cmd_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign pop_cmd  = slot_r[rp_r];
  assign st.full  = (cnt_r == 2'd2);
  assign st.empty = (cnt_r == 2'd0);
endmodule

// ===== src/rfft_back.sv =====
`timescale 1ns / 1ps
module rfft_back
  import rfft_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  q_stat_t                  q_st,
  input  cmd_t                     cmd,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_bin_re,
  output logic signed [DATA_W-1:0] out_bin_im,
  output logic [ADDR_W-1:0]        out_index,
  output logic                     out_ready_res
);
  typedef enum logic [3:0] {
    S_IDLE, S_RDW, T_RDA, T_RDB, T_M1, T_M2, T_RND, T_WA, T_WB
  } state_t;

  localparam int PROD_W = DATA_W + SMP_W;
  localparam int T_W    = PROD_W + 1 - 15;

  state_t                    state_r;
  logic [LG_W-1:0]           lg_r, s_r;
  logic [TW_W-1:0]           j_r;
  logic signed [SMP_W-1:0]   cos_r, sin_r;
  logic signed [DATA_W-1:0]  a_re_r, a_im_r, b_re_r, b_im_r, nb_re_r, nb_im_r;
  logic signed [PROD_W-1:0]  p1_r, p2_r, p3_r, p4_r;
  logic signed [T_W-1:0]     tr_r, ti_r;
  logic                      out_valid_r, out_rdy_r;
  logic signed [DATA_W-1:0]  out_re_r, out_im_r;
  logic [ADDR_W-1:0]         out_idx_r;

  logic                      we;
  logic [ADDR_W-1:0]         waddr, raddr, ia, ib, half, kk;
  logic [2*DATA_W-1:0]       wdata, rdata;
  logic [TW_W-1:0]           tw;
  logic                      stage_end;
  logic                      out_set;
  logic signed [DATA_W-1:0]  rd_re, rd_im;

  function automatic logic signed [T_W-1:0] rnd(input logic signed [PROD_W:0] p);
    logic signed [PROD_W:0] q;
    q = p + (PROD_W+1)'(16384);
    return q[PROD_W:15];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [T_W:0] v);
    logic signed [T_W:0] hi, lo;
    hi = (T_W+1)'((1 << (DATA_W-1)) - 1);
    lo = -hi - 1'b1;
    priority if (v > hi) return hi[DATA_W-1:0];
    else if (v < lo)     return lo[DATA_W-1:0];
    else                 return v[DATA_W-1:0];
  endfunction

  assign rd_re = rdata[2*DATA_W-1:DATA_W];
  assign rd_im = rdata[DATA_W-1:0];

  // Butterfly addressing from stage and butterfly counters.
  assign half      = ADDR_W'(1) << (s_r - 1'b1);
  assign kk        = {1'b0, j_r} & (half - 1'b1);
  assign ia        = ((({1'b0, j_r}) >> (s_r - 1'b1)) << s_r) | kk;
  assign ib        = ia | half;
  assign tw        = TW_W'(kk << (LG_W'(PTS_LOG2) - s_r));
  assign stage_end = ({1'b0, j_r} == ((ADDR_W'(1) << (lg_r - 1'b1)) - 1'b1));

  // A result appears after a bin read, or at once for a read before done.
  assign out_set = (state_r == S_RDW) ||
                   (state_r == S_IDLE && pop && cmd.kind == REQ_READ && !cmd.done);

  always_comb begin
    pop   = 1'b0;
    we    = 1'b0;
    waddr = ia;
    wdata = {sat((T_W+1)'(a_re_r) + (T_W+1)'(tr_r)), sat((T_W+1)'(a_im_r) + (T_W+1)'(ti_r))};
    raddr = ia;
    unique case (state_r)
      S_IDLE: begin
        pop   = !q_st.empty && (cmd.kind == REQ_LOAD || !out_valid_r || out_ready);
        we    = pop && cmd.kind == REQ_LOAD;
        waddr = cmd.addr;
        wdata = {DATA_W'(cmd.re), DATA_W'(cmd.im)};
        raddr = cmd.addr;
      end
      T_RDB:   raddr = ib;
      T_WA:    we = 1'b1;
      T_WB: begin
        we    = 1'b1;
        waddr = ib;
        wdata = {nb_re_r, nb_im_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_set)                       out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (pop) begin
          if (cmd.kind == REQ_LOAD) begin
            if (cmd.last) begin
              lg_r    <= cmd.lg;
              s_r     <= LG_W'(1);
              j_r     <= '0;
              state_r <= T_RDA;
            end
          end else begin
            out_idx_r <= cmd.addr;
            out_rdy_r <= cmd.done;
            if (cmd.done) begin
              state_r <= S_RDW;
            end else begin
              out_re_r <= '0;
              out_im_r <= '0;
            end
          end
        end
        S_RDW: begin
          out_re_r <= rd_re;
          out_im_r <= rd_im;
          state_r  <= S_IDLE;
        end
        T_RDA: begin
          cos_r   <= COS_TAB[tw];
          sin_r   <= SIN_TAB[tw];
          state_r <= T_RDB;
        end
        T_RDB: begin
          a_re_r  <= rd_re;
          a_im_r  <= rd_im;
          state_r <= T_M1;
        end
        T_M1: begin
          b_re_r  <= rd_re;
          b_im_r  <= rd_im;
          p1_r    <= rd_re * cos_r;
          p2_r    <= rd_im * sin_r;
          state_r <= T_M2;
        end
        T_M2: begin
          p3_r    <= b_im_r * cos_r;
          p4_r    <= b_re_r * sin_r;
          tr_r    <= rnd((PROD_W+1)'(p1_r) + (PROD_W+1)'(p2_r));
          state_r <= T_RND;
        end
        T_RND: begin
          ti_r    <= rnd((PROD_W+1)'(p3_r) - (PROD_W+1)'(p4_r));
          state_r <= T_WA;
        end
        T_WA: begin
          nb_re_r <= sat((T_W+1)'(a_re_r) - (T_W+1)'(tr_r));
          nb_im_r <= sat((T_W+1)'(a_im_r) - (T_W+1)'(ti_r));
          state_r <= T_WB;
        end
        T_WB: begin
          if (!stage_end) begin
            j_r     <= j_r + 1'b1;
            state_r <= T_RDA;
          end else begin
            j_r <= '0;
            if (s_r == lg_r) begin
              state_r <= S_IDLE;
            end else begin
              s_r     <= s_r + 1'b1;
              state_r <= T_RDA;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  rfft_ram #(.WIDTH(2*DATA_W), .DEPTH(PTS)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_bin_re    = out_re_r;
  assign out_bin_im    = out_im_r;
  assign out_index     = out_idx_r;
  assign out_ready_res = out_rdy_r;
endmodule

// ===== src/radix2_fft.sv =====
// Radix-2 DIT FFT, 2..1024 points, Q1.15 in, 27-bit unscaled bins out.
// Loads: one word per cycle while the 2-entry queue is not full, stored when popped.
// Transform: the single butterfly unit steps T_RDA, T_RDB, T_M1, T_M2, T_RND, T_WA, T_WB
// for each butterfly, writing both results through the one store write port.
// Reads: a bin of a done frame is fetched from the store via S_RDW; before done, zero.
// Reset (rst_n low, synchronous): size 16 points, no frame loaded, queue empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module radix2_fft
  import rfft_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [LG_W-1:0]          cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic signed [SMP_W-1:0]  in_sample_re,
  input  logic signed [SMP_W-1:0]  in_sample_im,
  input  logic [ADDR_W-1:0]        in_bin_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_bin_re,
  output logic signed [DATA_W-1:0] out_bin_im,
  output logic [ADDR_W-1:0]        out_index,
  output logic                     out_ready_res
);
  q_stat_t     q_st;
  front_stat_t f_st;
  cmd_t        push_cmd, pop_cmd;
  logic        push, pop;

  // Front: classify words, track frame fill, compute store addresses.
  rfft_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .in_req_type,
    .in_sample_re, .in_sample_im, .in_bin_index, .q_st, .push, .push_cmd, .st(f_st)
  );

  // Hold commands while the back end is busy transforming.
  rfft_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .pop, .pop_cmd, .st(q_st)
  );

  // Back: store writes, butterfly engine, bin readout.
  rfft_back u_back (
    .clk, .rst_n, .q_st, .cmd(pop_cmd), .pop, .out_valid, .out_ready,
    .out_bin_re, .out_bin_im, .out_index, .out_ready_res
  );

  `CHK_IMPLIES(a_no_push_full, q_st.full, !in_ready)
  `CHK_IMPLIES(a_no_pop_empty, q_st.empty, !pop)
  `CHK_IMPLIES(a_zero_not_ready, out_valid && !out_ready_res, out_bin_re == '0 && out_bin_im == '0)
  `CHK_IMPLIES(a_cfg_clears, $past(cfg_we) && $past(rst_n), !f_st.done)
endmodule

// ===== bench/radix2_fft_test.sv =====
`timescale 1ns / 1ps
module radix2_fft_test;
  import rfft_pkg::*;

  // One word on the input channel.
  typedef struct {
    req_t                    kind;
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
    logic [ADDR_W-1:0]       idx;
  } fft_word_t;

  // One bin as the block should return it.
  typedef struct {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic [ADDR_W-1:0]        idx;
    logic                     rdy;
  } bin_word_t;

  localparam longint DATA_HI = (64'sd1 <<< (DATA_W - 1)) - 1;
  localparam longint DATA_LO = -(64'sd1 <<< (DATA_W - 1));

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [LG_W-1:0]          cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_req_type = 1'b0;
  logic signed [SMP_W-1:0]  in_sample_re = '0;
  logic signed [SMP_W-1:0]  in_sample_im = '0;
  logic [ADDR_W-1:0]        in_bin_index = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_bin_re;
  logic signed [DATA_W-1:0] out_bin_im;
  logic [ADDR_W-1:0]        out_index;
  logic                     out_ready_res;

  radix2_fft dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_sample_re  (in_sample_re),
    .in_sample_im  (in_sample_im),
    .in_bin_index  (in_bin_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bin_re    (out_bin_re),
    .out_bin_im    (out_bin_im),
    .out_index     (out_index),
    .out_ready_res (out_ready_res)
  );

  always #4 clk = ~clk;

  fft_word_t word_queue[$];
  bin_word_t bin_queue[$];
  int        err_count = 0;
  int        bins_seen = 0;

  // Shadow of the block: point store, frame fill level, size register.
  longint          pt_re [PTS];
  longint          pt_im [PTS];
  longint          rom_cos [TW_DEPTH];
  longint          rom_sin [TW_DEPTH];
  int              fill_cnt;
  bit              frame_done;
  logic [LG_W-1:0] size_reg;

  // Fill the twiddle ROM with the Q30 Taylor series, rounded to Q1.15.
  task automatic build_twiddles();
    longint unsigned x, x2, tc, ts, jj;
    longint sc, ss, cq, sq;
    bit flip;
    for (int j = 0; j < TW_DEPTH; j++) begin
      flip = (4 * j > PTS);
      jj = flip ? (TW_DEPTH - j) : j;
      x = (2 * PI_Q30 * jj) / PTS;
      x2 = (x * x) >> 30;
      tc = ONE_Q30;
      ts = x;
      sc = ONE_Q30;
      ss = x;
      for (int n = 1; n <= 12; n++) begin
        tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
        ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sc -= tc;
          ss -= ts;
        end else begin
          sc += tc;
          ss += ts;
        end
      end
      // clamp to Q1.15: negatives to zero, cos(0) to 32767
      cq = (sc < 0) ? 0 : (sc + 16384) >>> 15;
      sq = (ss < 0) ? 0 : (ss + 16384) >>> 15;
      if (cq > 32767) cq = 32767;
      if (sq > 32767) sq = 32767;
      rom_cos[j] = flip ? -cq : cq;
      rom_sin[j] = sq;
    end
  endtask

  function automatic int frame_log2();
    if (size_reg < 1) return 1;
    if (size_reg > PTS_LOG2) return PTS_LOG2;
    return size_reg;
  endfunction

  function automatic longint round_prod(input longint p);
    if (p >= 0) return (p + 16384) >>> 15;
    return -(((-p) + 16383) >>> 15);
  endfunction

  function automatic longint clip27(input longint v);
    if (v > DATA_HI) return DATA_HI;
    if (v < DATA_LO) return DATA_LO;
    return v;
  endfunction

  // In-place DIT transform of the first 2^lg points of the shadow store.
  task automatic fft_in_place(input int lg);
    int n, r, m, half, stride, ia, ib;
    longint t, c, sn, br, bi, tr, ti, ar, ai;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int b = 0; b < lg; b++) r |= ((i >> b) & 1) << (lg - 1 - b);
      if (r > i) begin
        t = pt_re[i]; pt_re[i] = pt_re[r]; pt_re[r] = t;
        t = pt_im[i]; pt_im[i] = pt_im[r]; pt_im[r] = t;
      end
    end
    for (int s = 1; s <= lg; s++) begin
      m = 1 << s;
      half = m >> 1;
      stride = PTS >> s;
      for (int base = 0; base < n; base += m) begin
        for (int k = 0; k < half; k++) begin
          ia = base + k;
          ib = ia + half;
          c = rom_cos[k * stride];
          sn = rom_sin[k * stride];
          br = pt_re[ib];
          bi = pt_im[ib];
          tr = round_prod(br * c + bi * sn);
          ti = round_prod(bi * c - br * sn);
          ar = pt_re[ia];
          ai = pt_im[ia];
          pt_re[ia] = clip27(ar + tr);
          pt_im[ia] = clip27(ai + ti);
          pt_re[ib] = clip27(ar - tr);
          pt_im[ib] = clip27(ai - ti);
        end
      end
    end
  endtask

  // Advance the shadow by one accepted word; queue the bin a read returns.
  task automatic fft_predict(input fft_word_t w);
    int lg, n;
    bin_word_t b;
    lg = frame_log2();
    n = 1 << lg;
    if (w.kind == REQ_LOAD) begin
      if (frame_done) begin
        frame_done = 0;
        fill_cnt = 0;
      end
      pt_re[fill_cnt] = w.re;
      pt_im[fill_cnt] = w.im;
      fill_cnt++;
      if (fill_cnt >= n) begin
        fft_in_place(lg);
        frame_done = 1;
        fill_cnt = 0;
      end
    end else begin
      b.idx = w.idx & ADDR_W'(n - 1);
      b.re = frame_done ? DATA_W'(pt_re[b.idx]) : '0;
      b.im = frame_done ? DATA_W'(pt_im[b.idx]) : '0;
      b.rdy = frame_done;
      bin_queue.push_back(b);
    end
  endtask

  // Driver: hold each word until taken, then wait its drawn gap.
  int drv_gap = 0;
  bit drv_burst = 0;
  always @(posedge clk) begin
    fft_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        w.kind = req_t'(in_req_type);
        w.re = in_sample_re;
        w.im = in_sample_im;
        w.idx = in_bin_index;
        fft_predict(w);
      end
      if (drv_gap > 0) begin
        drv_gap--;
        in_valid <= 1'b0;
      end else if (word_queue.size() > 0) begin
        w = word_queue.pop_front();
        in_req_type <= w.kind;
        in_sample_re <= w.re;
        in_sample_im <= w.im;
        in_bin_index <= w.idx;
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) drv_burst = !drv_burst;
        drv_gap = drv_burst ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each bin against the oldest expectation, then stall a while.
  int mon_hold = 0;
  bit mon_burst = 0;
  always @(posedge clk) begin
    bin_word_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      mon_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        bins_seen++;
        if (bin_queue.size() == 0) begin
          $display("%0t: unexpected bin re=%0d im=%0d idx=%0d rdy=%0b", $time,
                   out_bin_re, out_bin_im, out_index, out_ready_res);
          err_count++;
        end else begin
          e = bin_queue.pop_front();
          if (out_bin_re !== e.re || out_bin_im !== e.im || out_index !== e.idx ||
              out_ready_res !== e.rdy) begin
            $display("%0t: bin mismatch expected re=%0d im=%0d idx=%0d rdy=%0b",
                     $time, e.re, e.im, e.idx, e.rdy);
            $display("%0t:              actual   re=%0d im=%0d idx=%0d rdy=%0b",
                     $time, out_bin_re, out_bin_im, out_index, out_ready_res);
            err_count++;
          end
        end
        if ($urandom_range(0, 29) == 0) mon_burst = !mon_burst;
        mon_hold = mon_burst ? 0 : $urandom_range(0, 5);
        // hold off long once so the block backs up into its input
        if (bins_seen == 40) mon_hold = 400;
      end
      if (mon_hold > 0) begin
        mon_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_load(input logic signed [SMP_W-1:0] re,
                           input logic signed [SMP_W-1:0] im);
    fft_word_t w;
    w.kind = REQ_LOAD;
    w.re = re;
    w.im = im;
    w.idx = ADDR_W'($urandom);
    word_queue.push_back(w);
  endtask

  task automatic push_read(input logic [ADDR_W-1:0] idx);
    fft_word_t w;
    w.kind = REQ_READ;
    w.re = SMP_W'($urandom);
    w.im = SMP_W'($urandom);
    w.idx = idx;
    word_queue.push_back(w);
  endtask

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Drain everything, then let the block settle.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (word_queue.size() > 0 || in_valid || bin_queue.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(input logic [LG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    size_reg = v;
    fill_cnt = 0;
    frame_done = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random frames: full loads with reads after; some reads mid-frame as noise.
  task automatic random_frames(input int frames);
    int n;
    n = 1 << frame_log2();
    repeat (frames) begin
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) push_read(ADDR_W'($urandom));
        push_load(rand_sample(), rand_sample());
      end
      repeat ($urandom_range(2, 8)) push_read(ADDR_W'($urandom));
    end
  endtask

  logic [LG_W-1:0] sizes [$] = '{4'd1, 4'd0, 4'd3, 4'd2, 4'd5, 4'd6, 4'd4, 4'd3};
  int rand_words = 0;

  initial begin
    build_twiddles();
    size_reg = SIZE_RESET;
    fill_cnt = 0;
    frame_done = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed at reset size (16 points): read before done, extremes, wrap.
    push_read(10'd1023);
    push_load(16'sh7fff, 16'sh7fff);
    push_load(16'sh8000, 16'sh8000);
    push_load(16'sh7fff, 16'sh8000);
    push_load(16'sh8000, 16'sh7fff);
    push_load(16'sd0, 16'sd0);
    push_load(16'sd1, -16'sd1);
    for (int i = 0; i < 10; i++) push_load(16'sh8000, 16'sh8000);
    push_read(10'd0);
    push_read(10'd15);
    push_read(10'd16);
    push_read(10'd1023);
    // load after done restarts the frame; then abort it with a size write
    push_load(16'sd100, -16'sd100);
    push_load(16'sh7fff, 16'sd0);
    push_read(10'd5);
    wait_idle();

    // Out-of-range size clamps to the largest frame; partial load, reads before done.
    write_size(4'd15);
    repeat (3) push_load(rand_sample(), rand_sample());
    push_read(10'd1023);
    push_read(10'd517);
    wait_idle();

    // Size 10 written, frame left partial and aborted.
    write_size(4'd10);
    repeat (10) push_load(rand_sample(), rand_sample());
    push_read(ADDR_W'($urandom));
    wait_idle();

    while (rand_words < 560) begin
      foreach (sizes[i]) begin
        write_size(sizes[i]);
        random_frames($urandom_range(2, 4));
        rand_words += word_queue.size();
        // leave some frames half loaded before the next size write
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) push_load(rand_sample(), rand_sample());
          push_read(ADDR_W'($urandom));
        end
        wait_idle();
        if (rand_words >= 560) break;
      end
    end

    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("radix2_fft_test: clean");
    end else begin
      $display("radix2_fft_test: errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("radix2_fft_test: errors");
    $finish;
  end

endmodule
